// ----- rtl/crtb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Channel remap table builder package
// Shared types and constants for the controller, datapath and top level.
// ----------------------------------------------------------------------------
package crtb_pkg;

  // Width of the channel and mapped_channel result fields.
  localparam int CH_W = 6;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a new map and clear the counters
    logic scan;   // one step of the compaction pass
    logic emit;   // one step of the emission pass
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic chan_last;  // channel counter sits on the final channel
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/crtb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module crtb_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 37,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/crtb_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Channel remap table builder controller
// Sequences the compaction pass, the emission pass and the final drain cycle.
// ----------------------------------------------------------------------------
module crtb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire crtb_pkg::stat_t stat,
  output crtb_pkg::cmd_t      cmd,
  output logic                busy
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.chan_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.chan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // The final result is on the ports during this cycle.
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule
`default_nettype wire

// ----- rtl/crtb_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Channel remap table builder datapath
// Holds the rotating map, the channel and modulo counters, the used-channel
// list memory and the result stage.
// ----------------------------------------------------------------------------
module crtb_dpath #(
  parameter int NUM_CHANNELS = 37
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire crtb_pkg::cmd_t            cmd,
  input  wire logic [NUM_CHANNELS-1:0]   use_map,
  output crtb_pkg::stat_t                stat,
  output logic                           strobe,
  output logic [crtb_pkg::CH_W-1:0]      channel,
  output logic [crtb_pkg::CH_W-1:0]      mapped_channel,
  output logic                           last,
  output logic                           map_empty
);

  localparam int IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int USED_W = $clog2(NUM_CHANNELS + 1);

  logic [NUM_CHANNELS-1:0] scan_map;
  logic [IDX_W-1:0]        chan;
  logic [USED_W-1:0]       used;
  logic [IDX_W-1:0]        mod_idx;
  logic                    chan_last;
  logic                    mod_wrap;
  logic [IDX_W-1:0]        rdata;

  // Result stage registers.
  logic                    out_valid;
  logic [IDX_W-1:0]        out_chan;
  logic                    out_used_bit;
  logic                    out_last;

  assign chan_last      = (chan == IDX_W'(NUM_CHANNELS - 1));
  assign mod_wrap       = ((USED_W'(mod_idx) + USED_W'(1)) == used);
  assign stat.chan_last = chan_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_map <= use_map;
      chan     <= '0;
      used     <= '0;
      mod_idx  <= '0;
    end else if (cmd.scan || cmd.emit) begin
      // Rotating the map keeps the bit for the current channel at bit 0 and
      // restores the original map after each full pass.
      scan_map <= (scan_map >> 1) | (scan_map << (NUM_CHANNELS - 1));
      chan     <= chan_last ? '0 : chan + IDX_W'(1);
      if (cmd.scan && scan_map[0]) begin
        used <= used + USED_W'(1);
      end
      if (cmd.emit) begin
        mod_idx <= mod_wrap ? '0 : mod_idx + IDX_W'(1);
      end
    end
  end

  crtb_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_CHANNELS)
  ) u_list (
    .clk   (clk),
    .we    (cmd.scan && scan_map[0]),
    .waddr (used[IDX_W-1:0]),
    .wdata (chan),
    .raddr (mod_idx),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    out_chan     <= chan;
    out_used_bit <= scan_map[0];
    out_last     <= chan_last;
  end

  assign strobe    = out_valid;
  assign channel   = crtb_pkg::CH_W'(out_chan);
  assign last      = out_last;
  assign map_empty = (used == '0);

  always_comb begin
    priority if (map_empty) begin
      mapped_channel = '0;
    end else if (out_used_bit) begin
      mapped_channel = crtb_pkg::CH_W'(out_chan);
    end else begin
      mapped_channel = crtb_pkg::CH_W'(rdata);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/channel_remap_table_builder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Channel remap table builder
// Builds the channel remap table of the channel selection remap scheme from
// one channel-use map per request.
// ----------------------------------------------------------------------------
// A request is taken when start is high while busy is low. The block then
// makes one compaction pass over the map, one channel per cycle, writing the
// ascending list of used channels into a small RAM, followed by one emission
// pass that presents one result per cycle on strobe, in ascending channel
// order, with last on the final channel. The single channel counter walks
// the map twice, and the list RAM read is registered. The receiver cannot
// stall; every result is valid for exactly the one cycle in which strobe is
// high, and the results of a request come on consecutive cycles.
//
// A used channel maps to itself. An unused channel c maps to entry
// (c mod U) of the list of the U used channels; the modulo index is kept by
// a counter that wraps at U, so no divider is needed. When no channel is in
// use, every result reports mapped_channel 0 with map_empty set.
// ----------------------------------------------------------------------------
module channel_remap_table_builder_core #(
  parameter int NUM_CHANNELS = 37
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [NUM_CHANNELS-1:0]   use_map,
  output logic                           strobe,
  output logic [crtb_pkg::CH_W-1:0]      channel,
  output logic [crtb_pkg::CH_W-1:0]      mapped_channel,
  output logic                           last,
  output logic                           map_empty
);

  crtb_pkg::cmd_t  cmd;
  crtb_pkg::stat_t stat;

  // The controller sequences the passes; it only accepts a start in idle.
  crtb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the map, the counters, the list RAM and the result
  // stage that drives the result ports.
  crtb_dpath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .use_map        (use_map),
    .stat           (stat),
    .strobe         (strobe),
    .channel        (channel),
    .mapped_channel (mapped_channel),
    .last           (last),
    .map_empty      (map_empty)
  );

endmodule
`default_nettype wire

// ----- rtl/crtb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Channel remap table builder checker
// Port-level properties of the request and result sequencing.
// ----------------------------------------------------------------------------
module crtb_checker #(
  parameter int NUM_CHANNELS = 37
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      strobe,
  input wire logic [crtb_pkg::CH_W-1:0] mapped_channel,
  input wire logic                      last,
  input wire logic                      map_empty
);

  // Results only appear while a request is in progress.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result strobe while not busy");

  // A taken request starts the compaction pass, which shows no result.
  a_start_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !strobe))
    else $error("request not followed by a quiet busy cycle");

  // Results of one request come back to back until the last one.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside a result burst");

  // The block is free again right after the final result.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !busy)
    else $error("still busy after the final result");

  // An empty map always reports channel 0.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && map_empty) |-> (mapped_channel == '0))
    else $error("empty map with nonzero mapped channel");

endmodule

bind channel_remap_table_builder_core crtb_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_crtb_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .strobe         (strobe),
  .mapped_channel (mapped_channel),
  .last           (last),
  .map_empty      (map_empty)
);
`default_nettype wire
